/* sv/elr_pkg.sv */
`default_nettype none

package elr_pkg;

    localparam int DEF_COORD_BITS  = 13;
    localparam int DEF_RADIUS_BITS = 11;
    localparam int FRAME_BITS      = 13;
    localparam int COLOR_BITS      = 32;
    localparam int CFG_IDX_BITS    = 1;

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ARC  = 2'd1;
    localparam logic [1:0] PH_TAIL = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef struct packed {
        logic       start_latch;
        logic       mul1;
        logic       mul2;
        logic       sum;
        logic       load;
        logic [1:0] k;
    } t_cmd;

    typedef struct packed {
        logic [1:0] phase;
        logic       can_load;
    } t_status;

    // index of the final point that one step request emits in a given phase
    function automatic logic [1:0] last_index(input logic [1:0] phase);
        logic [1:0] idx;
        case (phase)
            PH_ARC:  idx = 2'd3;
            PH_TAIL: idx = 2'd1;
            default: idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

/* sv/elr_in_if.sv */
`default_nettype none

interface elr_in_if import elr_pkg::*; #(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int RADIUS_BITS = DEF_RADIUS_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0] radius_x;
    logic        [RADIUS_BITS-1:0] radius_y;
    logic        [COLOR_BITS-1:0]  draw_color;

    modport source (
        output valid, func, center_x, center_y, radius_x, radius_y, draw_color,
        input  ready
    );

    modport sink (
        input  valid, func, center_x, center_y, radius_x, radius_y, draw_color,
        output ready
    );
endinterface

`default_nettype wire

/* sv/elr_out_if.sv */
`default_nettype none

interface elr_out_if import elr_pkg::*; #(
    parameter int COORD_BITS = DEF_COORD_BITS
);
    logic                    valid;
    logic                    ready;
    logic [COORD_BITS-2:0]   pixel_x;
    logic [COORD_BITS-2:0]   pixel_y;
    logic [COLOR_BITS-1:0]   pixel_color;
    logic                    visible;
    logic                    last;
    logic                    done_res;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, visible, last, done_res,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, visible, last, done_res,
        output ready
    );
endinterface

`default_nettype wire

/* sv/ellipse_rasterizer.sv */
// Midpoint ellipse rasterizer, one outline point per result.
// Input channel i_in carries requests: func = start latches center, radii and
// color and sets up the error accumulators; func = step emits the next points.
// Output channel o_out carries points, with visible = 0 for points outside the
// frame, last on the final point of a request and done_res once the outline
// is finished. A step after completion returns one empty point with done_res.
// Frame width and height are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no request is in flight, as the block does not enforce this.
// Sequencing: after a start is accepted the controller passes through the multiply
// states MUL1 and MUL2 and the add state SUM. A step enters the run state and loads
// one point per cycle while the output register can take it; the next request is
// taken in the cycle that loads the last point, so an arc step emits four points,
// a tail step two and an empty step one. The single output register paces the loads.
// When o_out.ready is low with a point held, the output register holds and point
// generation stalls with it. Reset clears the frame size to 640 x 480, drops any
// pending point and returns the block to idle with no ellipse active.
`default_nettype none

module ellipse_rasterizer import elr_pkg::*; #(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int RADIUS_BITS = DEF_RADIUS_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    elr_in_if.sink                       i_in,
    elr_out_if.source                    o_out,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [FRAME_BITS-1:0]   i_cfg_data
);

    t_cmd    cmd;
    t_status stat;
    logic    in_ready;
    logic    in_accept;

    assign i_in.ready = in_ready;
    assign in_accept  = i_in.valid && in_ready;

    elr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_func     (i_in.func),
        .o_in_ready (in_ready),
        .i_status   (stat),
        .o_cmd      (cmd)
    );

    elr_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_center_x    (i_in.center_x),
        .i_center_y    (i_in.center_y),
        .i_radius_x    (i_in.radius_x),
        .i_radius_y    (i_in.radius_y),
        .i_draw_color  (i_in.draw_color),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_pixel_x     (o_out.pixel_x),
        .o_pixel_y     (o_out.pixel_y),
        .o_pixel_color (o_out.pixel_color),
        .o_visible     (o_out.visible),
        .o_last        (o_out.last),
        .o_done_res    (o_out.done_res)
    );

`ifndef SYNTHESIS
    a_start_setup : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in.func == FUNC_START |=> cmd.mul1)
        else $error("start request did not enter setup");

    a_setup_arc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sum |=> stat.phase == PH_ARC)
        else $error("setup did not arm the arc phase");

    a_hidden_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.visible |-> o_out.pixel_x == '0 && o_out.pixel_y == '0)
        else $error("hidden point carries coordinates");
`endif

endmodule

`default_nettype wire

/* sv/elr_ctrl.sv */
`default_nettype none

module elr_ctrl import elr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_func,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_RUN  = 3'd4;

    logic [2:0] r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       load;
    logic       final_load;
    logic       accept;

    assign load       = (r_state == S_RUN) && i_status.can_load;
    assign final_load = load && (r_k == last_index(i_status.phase));
    assign o_in_ready = (r_state == S_IDLE) || final_load;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_IDLE;
            end
            S_RUN: begin
                if (final_load) begin
                    n_state = S_IDLE;
                end else if (load) begin
                    n_k = r_k + 2'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (accept) begin
            n_state = (i_func == FUNC_START) ? S_MUL1 : S_RUN;
            n_k     = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        o_cmd.start_latch = accept && (i_func == FUNC_START);
        o_cmd.mul1        = (r_state == S_MUL1);
        o_cmd.mul2        = (r_state == S_MUL2);
        o_cmd.sum         = (r_state == S_SUM);
        o_cmd.load        = load;
        o_cmd.k           = r_k;
    end

endmodule

`default_nettype wire

/* sv/elr_datapath.sv */
`default_nettype none

module elr_datapath import elr_pkg::*; #(
    parameter int COORD_BITS  = DEF_COORD_BITS,
    parameter int RADIUS_BITS = DEF_RADIUS_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cmd                          i_cmd,
    output t_status                            o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire logic [FRAME_BITS-1:0]         i_cfg_data,
    input  wire logic signed [COORD_BITS-1:0]  i_center_x,
    input  wire logic signed [COORD_BITS-1:0]  i_center_y,
    input  wire logic [RADIUS_BITS-1:0]        i_radius_x,
    input  wire logic [RADIUS_BITS-1:0]        i_radius_y,
    input  wire logic [COLOR_BITS-1:0]         i_draw_color,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [COORD_BITS-2:0]              o_pixel_x,
    output logic [COORD_BITS-2:0]              o_pixel_y,
    output logic [COLOR_BITS-1:0]              o_pixel_color,
    output logic                               o_visible,
    output logic                               o_last,
    output logic                               o_done_res
);

    localparam int RB    = RADIUS_BITS;
    localparam int CW    = COORD_BITS;
    localparam int SQ_W  = 2 * RB;
    localparam int INC_W = 2 * RB + 1;
    localparam int PRW   = 3 * RB + 3;
    localparam int EW    = 4 * RB + 4;
    localparam int XW    = RB + 2;
    localparam int YW    = RB + 1;
    localparam int PW    = ((CW > RB + 2) ? CW : RB + 2) + 1;
    localparam int LW    = ((PW > FRAME_BITS) ? PW : FRAME_BITS) + 1;
    localparam logic [LW-1:0] CAP = LW'(1) << (CW - 1);

    logic [FRAME_BITS-1:0]  r_frame_w, r_frame_h;
    logic [1:0]             r_phase;
    logic signed [XW-1:0]   r_sx;
    logic [YW-1:0]          r_sy;
    logic signed [EW-1:0]   r_err, r_xinc, r_yinc;
    logic [INC_W-1:0]       r_tbs, r_tas;
    logic signed [CW-1:0]   r_cx, r_cy;
    logic [RB-1:0]          r_a, r_b;
    logic [COLOR_BITS-1:0]  r_color;
    logic [SQ_W-1:0]        r_a2, r_b2;
    logic                   r_fx, r_fy;
    logic [1:0]             r_nph;
    logic signed [EW-1:0]   r_cxi, r_cyi;

    logic                   r_ov;
    logic [CW-2:0]          r_px, r_py;
    logic [COLOR_BITS-1:0]  r_pc;
    logic                   r_vis, r_last, r_done;

    logic [SQ_W-1:0]        sq_a, sq_b;
    logic [XW-1:0]          one_m2a;
    logic [PRW-1:0]         prod;
    logic signed [EW:0]     e2, xinc_w, yinc_w;
    logic                   fx_c, fy_c;
    logic signed [XW-1:0]   sx_n;
    logic [YW-1:0]          sy_n, sy1;
    logic [1:0]             nph_arc;
    logic                   tail_done;
    logic                   is_arc, is_tail;
    logic signed [PW-1:0]   sx_ext, y_ext, y1_ext, cx_ext, cy_ext;
    logic signed [PW-1:0]   xt, yt, px, py;
    logic [LW-1:0]          fw_ext, fh_ext, lim_w, lim_h;
    logic                   vis;
    logic                   done_now;
    logic                   last_now;

    // setup arithmetic
    assign sq_a    = {{RB{1'b0}}, r_a} * {{RB{1'b0}}, r_a};
    assign sq_b    = {{RB{1'b0}}, r_b} * {{RB{1'b0}}, r_b};
    assign one_m2a = XW'(1) - {1'b0, r_a, 1'b0};
    assign prod    = PRW'($signed(one_m2a) * $signed({1'b0, r_b2}));

    // error decision of one arc step
    assign e2      = {r_err, 1'b0};
    assign xinc_w  = {r_xinc[EW-1], r_xinc};
    assign yinc_w  = {r_yinc[EW-1], r_yinc};
    assign fx_c    = (e2 >= xinc_w);
    assign fy_c    = (e2 <= yinc_w);
    assign sx_n    = r_sx + $signed({{(XW-1){1'b0}}, fx_c});
    assign sy_n    = r_sy + {{(YW-1){1'b0}}, fy_c};
    assign nph_arc = (!sx_n[XW-1] && (sx_n != '0))
                     ? ((sy_n < {1'b0, r_b}) ? PH_TAIL : PH_DONE) : PH_ARC;

    assign sy1       = r_sy + YW'(1);
    assign tail_done = (sy1 >= {1'b0, r_b});

    assign is_arc  = (r_phase == PH_ARC);
    assign is_tail = (r_phase == PH_TAIL);

    // point of index k
    assign sx_ext = {{(PW-XW){r_sx[XW-1]}}, r_sx};
    assign y_ext  = {{(PW-YW){1'b0}}, r_sy};
    assign y1_ext = {{(PW-YW){1'b0}}, sy1};
    assign cx_ext = {{(PW-CW){r_cx[CW-1]}}, r_cx};
    assign cy_ext = {{(PW-CW){r_cy[CW-1]}}, r_cy};

    always_comb begin
        xt = '0;
        yt = '0;
        if (is_arc) begin
            xt = (i_cmd.k inside {2'd0, 2'd3}) ? -sx_ext : sx_ext;
            yt = (i_cmd.k inside {2'd0, 2'd1}) ? y_ext : -y_ext;
        end else if (is_tail) begin
            yt = (i_cmd.k == 2'd0) ? y1_ext : -y1_ext;
        end
    end

    assign px = cx_ext + xt;
    assign py = cy_ext + yt;

    assign fw_ext = {{(LW-FRAME_BITS){1'b0}}, r_frame_w};
    assign fh_ext = {{(LW-FRAME_BITS){1'b0}}, r_frame_h};
    assign lim_w  = (fw_ext > CAP) ? CAP : fw_ext;
    assign lim_h  = (fh_ext > CAP) ? CAP : fh_ext;
    assign vis    = (is_arc || is_tail)
                    && !px[PW-1] && ({{(LW-PW){1'b0}}, px} < lim_w)
                    && !py[PW-1] && ({{(LW-PW){1'b0}}, py} < lim_h);

    always_comb begin
        case (r_phase)
            PH_ARC:  done_now = (i_cmd.k == 2'd0) ? (nph_arc == PH_DONE) : (r_nph == PH_DONE);
            PH_TAIL: done_now = tail_done;
            default: done_now = 1'b1;
        endcase
    end

    assign last_now = (i_cmd.k == last_index(r_phase));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_WIDTH_RST;
            r_frame_h <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                default: begin
                    r_frame_w <= r_frame_w;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_cmd.sum) begin
            r_phase <= PH_ARC;
        end else if (i_cmd.load && is_arc && i_cmd.k == 2'd3) begin
            r_phase <= r_nph;
        end else if (i_cmd.load && is_tail && i_cmd.k == 2'd1) begin
            r_phase <= tail_done ? PH_DONE : PH_TAIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_latch) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_a     <= i_radius_x;
            r_b     <= i_radius_y;
            r_color <= i_draw_color;
        end
        if (i_cmd.mul1) begin
            r_a2 <= sq_a;
            r_b2 <= sq_b;
        end
        if (i_cmd.mul2) begin
            r_xinc <= {{(EW-PRW){prod[PRW-1]}}, prod};
            r_yinc <= {{(EW-SQ_W){1'b0}}, r_a2};
            r_tas  <= {r_a2, 1'b0};
            r_tbs  <= {r_b2, 1'b0};
        end
        if (i_cmd.sum) begin
            r_err <= r_xinc + r_yinc;
            r_sx  <= XW'(0) - {2'b00, r_a};
            r_sy  <= '0;
        end
        if (i_cmd.load && is_arc) begin
            case (i_cmd.k)
                2'd0: begin
                    r_fx  <= fx_c;
                    r_fy  <= fy_c;
                    r_nph <= nph_arc;
                    r_cxi <= r_xinc + $signed({{(EW-INC_W){1'b0}}, r_tbs});
                    r_cyi <= r_yinc + $signed({{(EW-INC_W){1'b0}}, r_tas});
                end
                2'd1: begin
                    if (r_fx) begin
                        r_xinc <= r_cxi;
                        r_err  <= r_err + r_cxi;
                    end
                    if (r_fy) begin
                        r_yinc <= r_cyi;
                    end
                end
                2'd2: begin
                    if (r_fy) begin
                        r_err <= r_err + r_cyi;
                    end
                end
                default: begin
                    r_sx <= r_sx + $signed({{(XW-1){1'b0}}, r_fx});
                    r_sy <= r_sy + {{(YW-1){1'b0}}, r_fy};
                end
            endcase
        end
        if (i_cmd.load && is_tail && i_cmd.k == 2'd1) begin
            r_sy <= sy1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= vis ? px[CW-2:0] : '0;
            r_py   <= vis ? py[CW-2:0] : '0;
            r_pc   <= (is_arc || is_tail) ? r_color : '0;
            r_vis  <= vis;
            r_last <= last_now;
            r_done <= done_now;
        end
    end

    assign o_status.phase    = r_phase;
    assign o_status.can_load = !r_ov || i_out_ready;

    assign o_out_valid   = r_ov;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_visible     = r_vis;
    assign o_last        = r_last;
    assign o_done_res    = r_done;

endmodule

`default_nettype wire

/* verif/ellipse_rasterizer_checker.sv */
module ellipse_rasterizer_checker import elr_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    elr_in_if                            i_in,
    elr_out_if                           i_out,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [FRAME_BITS-1:0]   i_cfg_data,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_points,
    output int                           o_visible
);

    localparam longint PIX_LIMIT = longint'(1) << (DEF_COORD_BITS - 1);

    typedef struct packed {
        logic [DEF_COORD_BITS-2:0] x;
        logic [DEF_COORD_BITS-2:0] y;
        logic [COLOR_BITS-1:0]     color;
        logic                      visible;
        logic                      last;
        logic                      done;
    } t_pixel;

    t_pixel pending_pixels[$];

    logic [FRAME_BITS-1:0]             frame_w = FRAME_WIDTH_RST;
    logic [FRAME_BITS-1:0]             frame_h = FRAME_HEIGHT_RST;
    logic [1:0]                        phase = PH_IDLE;
    logic signed [DEF_COORD_BITS-1:0]  cur_x = '0;
    logic [DEF_COORD_BITS-2:0]         cur_y = '0;
    logic signed [47:0]                err = '0;
    logic signed [47:0]                inc_x = '0;
    logic signed [47:0]                inc_y = '0;
    logic [23:0]                       b_sq_twice = '0;
    logic [23:0]                       a_sq_twice = '0;
    logic signed [DEF_COORD_BITS-1:0]  ctr_x = '0;
    logic signed [DEF_COORD_BITS-1:0]  ctr_y = '0;
    logic [DEF_RADIUS_BITS-1:0]        rad_y = '0;
    logic [COLOR_BITS-1:0]             color = '0;

    int mismatches = 0;
    int points = 0;
    int visible_seen = 0;

    function automatic longint frame_cap(input logic [FRAME_BITS-1:0] val);
        return (longint'(val) > PIX_LIMIT) ? PIX_LIMIT : longint'(val);
    endfunction

    function automatic t_pixel make_pixel(input longint px, input longint py,
                                          input logic fin, input logic done);
        t_pixel p;
        logic   vis;
        vis = px >= 0 && px < frame_cap(frame_w) && py >= 0 && py < frame_cap(frame_h);
        p = '0;
        if (vis) begin
            p.x = (DEF_COORD_BITS-1)'(px);
            p.y = (DEF_COORD_BITS-1)'(py);
        end
        p.color   = color;
        p.visible = vis;
        p.last    = fin;
        p.done    = done;
        return p;
    endfunction

    function automatic void rasterize_request(
        input logic                             func,
        input logic signed [DEF_COORD_BITS-1:0] cx,
        input logic signed [DEF_COORD_BITS-1:0] cy,
        input logic [DEF_RADIUS_BITS-1:0]       rx,
        input logic [DEF_RADIUS_BITS-1:0]       ry,
        input logic [COLOR_BITS-1:0]            col
    );
        longint a, b, e2, ox, oy, sx, sy;
        longint px[4];
        longint py[4];
        int     n;
        t_pixel empty;

        if (func == FUNC_START) begin
            a = longint'(rx);
            b = longint'(ry);
            ctr_x      = cx;
            ctr_y      = cy;
            rad_y      = ry;
            color      = col;
            cur_x      = DEF_COORD_BITS'(-a);
            cur_y      = '0;
            inc_x      = 48'((1 - 2 * a) * b * b);
            inc_y      = 48'(a * a);
            err        = 48'((1 - 2 * a) * b * b + a * a);
            b_sq_twice = 24'(2 * b * b);
            a_sq_twice = 24'(2 * a * a);
            phase      = PH_ARC;
            return;
        end

        ox = longint'(ctr_x);
        oy = longint'(ctr_y);
        sx = longint'(cur_x);
        sy = longint'(cur_y);
        n  = 0;
        if (phase == PH_ARC) begin
            px[0] = ox - sx; py[0] = oy + sy;
            px[1] = ox + sx; py[1] = oy + sy;
            px[2] = ox + sx; py[2] = oy - sy;
            px[3] = ox - sx; py[3] = oy - sy;
            n = 4;
            e2 = 2 * longint'(err);
            if (e2 >= longint'(inc_x)) begin
                cur_x = DEF_COORD_BITS'(sx + 1);
                inc_x = 48'(longint'(inc_x) + longint'(b_sq_twice));
                err   = 48'(longint'(err) + longint'(inc_x));
            end
            if (e2 <= longint'(inc_y)) begin
                cur_y = (DEF_COORD_BITS-1)'(sy + 1);
                inc_y = 48'(longint'(inc_y) + longint'(a_sq_twice));
                err   = 48'(longint'(err) + longint'(inc_y));
            end
            if (cur_x > 0)
                phase = (cur_y < rad_y) ? PH_TAIL : PH_DONE;
        end else if (phase == PH_TAIL) begin
            cur_y = (DEF_COORD_BITS-1)'(sy + 1);
            px[0] = ox; py[0] = oy + longint'(cur_y);
            px[1] = ox; py[1] = oy - longint'(cur_y);
            n = 2;
            if (cur_y >= rad_y)
                phase = PH_DONE;
        end else begin
            empty      = '0;
            empty.last = 1'b1;
            empty.done = 1'b1;
            pending_pixels.push_back(empty);
            return;
        end

        for (int k = 0; k < n; k++)
            pending_pixels.push_back(make_pixel(px[k], py[k], k == n - 1, phase == PH_DONE));
    endfunction

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            frame_w    = FRAME_WIDTH_RST;
            frame_h    = FRAME_HEIGHT_RST;
            phase      = PH_IDLE;
            cur_x      = '0;
            cur_y      = '0;
            err        = '0;
            inc_x      = '0;
            inc_y      = '0;
            b_sq_twice = '0;
            a_sq_twice = '0;
            ctr_x      = '0;
            ctr_y      = '0;
            rad_y      = '0;
            color      = '0;
            pending_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH)
                    frame_w = i_cfg_data;
                else if (i_cfg_idx == REG_FRAME_HEIGHT)
                    frame_h = i_cfg_data;
            end
            if (i_out.valid && i_out.ready) begin
                got.x       = i_out.pixel_x;
                got.y       = i_out.pixel_y;
                got.color   = i_out.pixel_color;
                got.visible = i_out.visible;
                got.last    = i_out.last;
                got.done    = i_out.done_res;
                points++;
                if (got.visible === 1'b1)
                    visible_seen++;
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected point %0d: x=%0d y=%0d color=%h vis=%b last=%b done=%b",
                                 points, got.x, got.y, got.color, got.visible, got.last,
                                 got.done);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("point %0d expected x=%0d y=%0d color=%h vis=%b last=%b done=%b",
                                     points, want.x, want.y, want.color, want.visible,
                                     want.last, want.done);
                            $display("point %0d actual   x=%0d y=%0d color=%h vis=%b last=%b done=%b",
                                     points, got.x, got.y, got.color, got.visible, got.last,
                                     got.done);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                rasterize_request(i_in.func, i_in.center_x, i_in.center_y, i_in.radius_x,
                                  i_in.radius_y, i_in.draw_color);
        end
        o_mismatches <= mismatches;
        o_pending    <= pending_pixels.size();
        o_points     <= points;
        o_visible    <= visible_seen;
    end

endmodule

/* verif/ellipse_rasterizer_test.sv */
module ellipse_rasterizer_test;
    import elr_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int PHASES        = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 24;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    logic [FRAME_BITS-1:0]   cfg_data;

    int mismatches;
    int pending;
    int points;
    int visible_pts;
    int cycles   = 0;
    int requests = 0;

    logic                  quiet_src  = 1'b0;
    logic                  quiet_sink = 1'b0;
    logic [FRAME_BITS-1:0] frame_w    = FRAME_WIDTH_RST;
    logic [FRAME_BITS-1:0] frame_h    = FRAME_HEIGHT_RST;

    elr_in_if  in_ch ();
    elr_out_if out_ch ();

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    ellipse_rasterizer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ellipse_rasterizer_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_points     (points),
        .o_visible    (visible_pts)
    );

    task automatic send_request(
        input logic                             func,
        input logic signed [DEF_COORD_BITS-1:0] cx,
        input logic signed [DEF_COORD_BITS-1:0] cy,
        input logic [DEF_RADIUS_BITS-1:0]       rx,
        input logic [DEF_RADIUS_BITS-1:0]       ry,
        input logic [COLOR_BITS-1:0]            col
    );
        int gap;
        gap = quiet_src ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= func;
        in_ch.center_x   <= cx;
        in_ch.center_y   <= cy;
        in_ch.radius_x   <= rx;
        in_ch.radius_y   <= ry;
        in_ch.draw_color <= col;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        requests++;
    endtask

    // step requests carry junk in the fields a step ignores
    task automatic advance(input int count);
        repeat (count)
            send_request(FUNC_STEP, DEF_COORD_BITS'($urandom), DEF_COORD_BITS'($urandom),
                         DEF_RADIUS_BITS'($urandom), DEF_RADIUS_BITS'($urandom), $urandom);
    endtask

    task automatic set_frame(input logic [FRAME_BITS-1:0] w, input logic [FRAME_BITS-1:0] h);
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx  <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
        frame_w = w;
        frame_h = h;
    endtask

    task automatic random_ellipse();
        int                             shape;
        int                             full;
        int                             n;
        int                             span_w;
        int                             span_h;
        logic signed [DEF_COORD_BITS-1:0] cx;
        logic signed [DEF_COORD_BITS-1:0] cy;
        logic [DEF_RADIUS_BITS-1:0]     rx;
        logic [DEF_RADIUS_BITS-1:0]     ry;

        quiet_src  = ($urandom_range(0, 4) == 0);
        quiet_sink = ($urandom_range(0, 4) == 0);
        shape = $urandom_range(0, 99);
        // stray steps with no new start before them
        if (shape < 8) begin
            advance($urandom_range(1, 3));
            return;
        end
        if (shape < 82) begin
            rx = DEF_RADIUS_BITS'($urandom_range(0, 8));
            ry = DEF_RADIUS_BITS'($urandom_range(0, 8));
        end else if (shape < 92) begin
            rx = DEF_RADIUS_BITS'($urandom_range(0, 24));
            ry = DEF_RADIUS_BITS'($urandom_range(0, 24));
        end else begin
            rx = DEF_RADIUS_BITS'($urandom);
            ry = DEF_RADIUS_BITS'($urandom);
        end

        span_w = (frame_w == 0) ? 64 : ((frame_w > 4200) ? 4200 : int'(frame_w));
        span_h = (frame_h == 0) ? 64 : ((frame_h > 4200) ? 4200 : int'(frame_h));
        case ($urandom_range(0, 9))
            7, 8: begin
                cx = DEF_COORD_BITS'($urandom);
                cy = DEF_COORD_BITS'($urandom);
            end
            9: begin
                cx = $urandom_range(0, 1) ? 13'sh0FFF : 13'sh1000;
                cy = $urandom_range(0, 1) ? 13'sh0FFF : 13'sh1000;
            end
            default: begin
                cx = DEF_COORD_BITS'(int'($urandom_range(0, span_w + 40)) - 20);
                cy = DEF_COORD_BITS'(int'($urandom_range(0, span_h + 40)) - 20);
            end
        endcase
        send_request(FUNC_START, cx, cy, rx, ry, $urandom);

        full = int'(rx) + int'(ry) + 2;
        if (shape >= 92)
            n = $urandom_range(1, 24);
        else if ($urandom_range(0, 6) == 0)
            n = $urandom_range(0, full);
        else
            n = full + $urandom_range(0, 2);
        advance(n);
    endtask

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            stall = quiet_sink ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
        end
    end

    initial begin
        int target;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.func       <= FUNC_START;
        in_ch.center_x   <= '0;
        in_ch.center_y   <= '0;
        in_ch.radius_x   <= '0;
        in_ch.radius_y   <= '0;
        in_ch.draw_color <= '0;
        cfg_we           <= 1'b0;
        cfg_idx          <= REG_FRAME_WIDTH;
        cfg_data         <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // step with no ellipse, then degenerate, extreme and tail-shaped outlines
        send_request(FUNC_STEP, '0, '0, '0, '0, '0);
        send_request(FUNC_START, 13'sd100, 13'sd100, 11'd0, 11'd0, 32'h0);
        advance(2);
        send_request(FUNC_START, 13'sh1000, 13'sh0FFF, 11'h7FF, 11'h7FF, 32'hFFFF_FFFF);
        advance(2);
        send_request(FUNC_START, 13'sh0FFF, 13'sh1000, 11'd3, 11'd0, $urandom);
        advance(5);
        send_request(FUNC_START, 13'sd320, 13'sd240, 11'd0, 11'd3, $urandom);
        advance(5);
        send_request(FUNC_START, 13'sd0, 13'sd0, 11'd2, 11'd1, $urandom);
        advance(5);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: set_frame(13'd4096, 13'd4096);
                2: set_frame(13'd8191, 13'd4097);
                3: set_frame(13'd1, 13'd1);
                4: set_frame(13'd0, 13'd8191);
                5: set_frame(13'd4097, 13'd0);
                6: set_frame(FRAME_BITS'($urandom_range(1, 700)),
                             FRAME_BITS'($urandom_range(1, 520)));
                default: ;
            endcase
            target = requests + RANDOM_ITEMS / PHASES;
            while (requests < target)
                random_ellipse();
        end

        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests across %0d frame sizes, including extreme and zero sizes;",
                 requests, PHASES);
        $display("%0d points checked, %0d of them inside the frame.", points, visible_pts);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
